// ----- src/alps_pkg.sv -----
package alps_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_TRIGGER = 2'd1;
    localparam logic [1:0] OP_ABORT   = 2'd2;

    // Sequencer phase codes.
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_BUZZ_ON  = 3'd1;
    localparam logic [2:0] PH_BUZZ_OFF = 3'd2;
    localparam logic [2:0] PH_VIBRATE  = 3'd3;
    localparam logic [2:0] PH_LED_ON   = 3'd4;
    localparam logic [2:0] PH_LED_OFF  = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_BUZZER_EN    = 3'd0;
    localparam logic [2:0] REG_VIBRATION_EN = 3'd1;
    localparam logic [2:0] REG_LED_EN       = 3'd2;
    localparam logic [2:0] REG_BUZZER_MS    = 3'd3;
    localparam logic [2:0] REG_VIBRATION_MS = 3'd4;
    localparam logic [2:0] REG_BLINK_MS     = 3'd5;
    localparam logic [2:0] REG_BLINK_COUNT  = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MS_W        = 16;
    localparam int BLINK_W     = 8;
    localparam int BEEP_W      = 2;

    localparam logic [BEEP_W-1:0] BEEPS_DROWSY = 2'd3;
    localparam logic [BEEP_W-1:0] BEEPS_NORMAL = 2'd2;

    localparam logic [MS_W-1:0]    RST_BUZZER_MS    = 16'd500;
    localparam logic [MS_W-1:0]    RST_VIBRATION_MS = 16'd1000;
    localparam logic [MS_W-1:0]    RST_BLINK_MS     = 16'd200;
    localparam logic [BLINK_W-1:0] RST_BLINK_COUNT  = 8'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic       alert_drowsy;
    } t_item;

    typedef struct packed {
        logic       buzz_level;
        logic       vibration_on;
        logic       led_on;
        logic       busy_res;
        logic [2:0] phase_now;
        logic       alert_done;
    } t_res;

    typedef struct packed {
        logic               buzzer_enable;
        logic               vibration_enable;
        logic               led_enable;
        logic [MS_W-1:0]    buzzer_ms;
        logic [MS_W-1:0]    vibration_ms;
        logic [MS_W-1:0]    blink_ms;
        logic [BLINK_W-1:0] blink_count;
    } t_cfg;

endpackage

// ----- src/alps_cfg.sv -----
module alps_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [alps_pkg::CFG_INDEX_W-1:0]  i_index,
    input  logic [alps_pkg::CFG_DATA_W-1:0]   i_data,
    output alps_pkg::t_cfg                    o_cfg
);
    import alps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buzzer_enable    <= 1'b1;
            r_cfg.vibration_enable <= 1'b1;
            r_cfg.led_enable       <= 1'b1;
            r_cfg.buzzer_ms        <= RST_BUZZER_MS;
            r_cfg.vibration_ms     <= RST_VIBRATION_MS;
            r_cfg.blink_ms         <= RST_BLINK_MS;
            r_cfg.blink_count      <= RST_BLINK_COUNT;
        end else if (i_wr) begin
            unique case (i_index)
                REG_BUZZER_EN:    r_cfg.buzzer_enable    <= i_data[0];
                REG_VIBRATION_EN: r_cfg.vibration_enable <= i_data[0];
                REG_LED_EN:       r_cfg.led_enable       <= i_data[0];
                REG_BUZZER_MS:    r_cfg.buzzer_ms        <= i_data[MS_W-1:0];
                REG_VIBRATION_MS: r_cfg.vibration_ms     <= i_data[MS_W-1:0];
                REG_BLINK_MS:     r_cfg.blink_ms         <= i_data[MS_W-1:0];
                REG_BLINK_COUNT:  r_cfg.blink_count      <= i_data[BLINK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/alps_in_reg.sv -----
module alps_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  alps_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_take,
    output alps_pkg::t_item o_item
);
    import alps_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The register refills in the same cycle that its word is taken.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- src/alps_core.sv -----
module alps_core #(
    parameter int TIME_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  alps_pkg::t_item i_item,
    input  alps_pkg::t_cfg  i_cfg,
    output alps_pkg::t_res  o_res
);
    import alps_pkg::*;

    localparam int CW = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;
    localparam logic [TIME_WIDTH-1:0] TMAX = {TIME_WIDTH{1'b1}};

    logic [2:0]            r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_elapsed, n_elapsed, elapsed_inc;
    logic [BEEP_W-1:0]     r_beeps, n_beeps, beeps_dec;
    logic [BLINK_W-1:0]    r_blinks, n_blinks, blinks_dec;
    logic                  start, end_direct, done;
    logic [2:0]            start_from, start_phase;

    // A length beyond the counter range counts as reached once the counter saturates.
    function automatic logic reach(input logic [TIME_WIDTH-1:0] e, input logic [MS_W-1:0] len);
        return (CW'(e) >= CW'(len)) || (e == TMAX);
    endfunction

    // Walks forward from a phase start, skipping disabled outputs.
    function automatic logic [2:0] first_phase(input logic [2:0] from, input t_cfg c);
        logic [2:0] p;
        p = PH_IDLE;
        if (from == PH_BUZZ_ON && c.buzzer_enable) begin
            p = PH_BUZZ_ON;
        end else if ((from == PH_BUZZ_ON || from == PH_VIBRATE) && c.vibration_enable) begin
            p = PH_VIBRATE;
        end else if (c.led_enable) begin
            p = PH_LED_ON;
        end
        return p;
    endfunction

    assign elapsed_inc = (r_elapsed == TMAX) ? r_elapsed : r_elapsed + TIME_WIDTH'(1);
    assign beeps_dec   = (r_beeps != '0) ? r_beeps - BEEP_W'(1) : '0;
    assign blinks_dec  = (r_blinks != '0) ? r_blinks - BLINK_W'(1) : '0;

    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_beeps    = r_beeps;
        n_blinks   = r_blinks;
        start      = 1'b0;
        start_from = PH_BUZZ_ON;
        end_direct = 1'b0;
        case (i_item.operation)
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_elapsed = elapsed_inc;
                    case (r_phase)
                        PH_BUZZ_ON: begin
                            if (reach(elapsed_inc, i_cfg.buzzer_ms)) begin
                                n_beeps = beeps_dec;
                                if (beeps_dec != '0) begin
                                    n_phase   = PH_BUZZ_OFF;
                                    n_elapsed = '0;
                                end else begin
                                    start      = 1'b1;
                                    start_from = PH_VIBRATE;
                                end
                            end
                        end
                        PH_BUZZ_OFF: begin
                            if (reach(elapsed_inc, i_cfg.buzzer_ms)) begin
                                start      = 1'b1;
                                start_from = PH_BUZZ_ON;
                            end
                        end
                        PH_VIBRATE: begin
                            if (reach(elapsed_inc, i_cfg.vibration_ms)) begin
                                start      = 1'b1;
                                start_from = PH_LED_ON;
                            end
                        end
                        PH_LED_ON: begin
                            if (reach(elapsed_inc, i_cfg.blink_ms)) begin
                                n_blinks  = blinks_dec;
                                n_elapsed = '0;
                                if (blinks_dec != '0) begin
                                    n_phase = PH_LED_OFF;
                                end else begin
                                    n_phase    = PH_IDLE;
                                    end_direct = 1'b1;
                                end
                            end
                        end
                        PH_LED_OFF: begin
                            if (reach(elapsed_inc, i_cfg.blink_ms)) begin
                                start      = 1'b1;
                                start_from = PH_LED_ON;
                            end
                        end
                        default: begin
                            n_phase   = PH_IDLE;
                            n_elapsed = '0;
                        end
                    endcase
                end
            end
            OP_TRIGGER: begin
                if (r_phase == PH_IDLE) begin
                    n_beeps    = i_item.alert_drowsy ? BEEPS_DROWSY : BEEPS_NORMAL;
                    n_blinks   = i_cfg.blink_count;
                    start      = 1'b1;
                    start_from = PH_BUZZ_ON;
                end
            end
            OP_ABORT: begin
                n_phase   = PH_IDLE;
                n_elapsed = '0;
                n_beeps   = '0;
                n_blinks  = '0;
            end
            default: begin
            end
        endcase
        start_phase = first_phase(start_from, i_cfg);
        if (start) begin
            n_phase   = start_phase;
            n_elapsed = '0;
        end
        done = end_direct || (start && start_phase == PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_beeps   <= '0;
            r_blinks  <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_beeps   <= n_beeps;
            r_blinks  <= n_blinks;
        end
    end

    always_comb begin
        o_res.buzz_level   = (n_phase == PH_BUZZ_ON);
        o_res.vibration_on = (n_phase == PH_VIBRATE);
        o_res.led_on       = (n_phase == PH_LED_ON);
        o_res.busy_res     = (n_phase != PH_IDLE);
        o_res.phase_now    = n_phase;
        o_res.alert_done   = done;
    end

endmodule

// ----- src/alert_pattern_sequencer.sv -----
// A word accepted into the input register is offered as a result from the result
// register. Throughput: one word per cycle while the output does not stall; the input
// register and the result register each refill in the cycle their word moves on, and
// the phase update is a single pass.
// Reset (synchronous, active low) returns the sequencer to idle with all counters at
// zero, restores the register defaults and empties both pipeline registers.
module alert_pattern_sequencer #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  alps_pkg::t_item                  i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output alps_pkg::t_res                   o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [alps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [alps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import alps_pkg::*;

    t_cfg  cfg;
    t_item item;
    t_res  res;
    logic  item_valid;
    logic  step;
    logic  res_free;
    logic  r_out_valid;
    t_res  r_out;

    assign o_cfg_ready = 1'b1;

    alps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    alps_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .o_valid (item_valid),
        .i_take  (step),
        .o_item  (item)
    );

    assign res_free = !r_out_valid || i_out_ready;
    assign step     = item_valid && res_free;

    alps_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- src/alps_checker.sv -----
module alps_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input alps_pkg::t_res                   o_out_data
);
    import alps_pkg::*;

    // A word left waiting stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // Drive levels and busy must follow the reported phase.
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.buzz_level == (o_out_data.phase_now == PH_BUZZ_ON))
            && (o_out_data.vibration_on == (o_out_data.phase_now == PH_VIBRATE))
            && (o_out_data.led_on == (o_out_data.phase_now == PH_LED_ON))
            && (o_out_data.busy_res == (o_out_data.phase_now != PH_IDLE)))
        else $error("drive levels disagree with phase");

    // A finished sequence always lands in idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.alert_done |-> o_out_data.phase_now == PH_IDLE)
        else $error("done reported outside idle");

    // Nothing comes out in the cycle right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind alert_pattern_sequencer alps_checker u_alps_checker (.*);

// ----- sim/alert_pattern_sequencer_test.sv -----
module alert_pattern_sequencer_test;
    import alps_pkg::*;

    localparam int TW = 16;
    localparam longint ELAPSED_MAX = (longint'(1) << TW) - 1;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_WORDS = 1050;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_item in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_res out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted sequencer state and register copy.
    t_cfg alert_cfg = '{buzzer_enable: 1'b1, vibration_enable: 1'b1, led_enable: 1'b1,
                        buzzer_ms: RST_BUZZER_MS, vibration_ms: RST_VIBRATION_MS,
                        blink_ms: RST_BLINK_MS, blink_count: RST_BLINK_COUNT};
    logic [2:0] ph = PH_IDLE;
    logic [TW-1:0] elapsed = '0;
    logic [BEEP_W-1:0] beeps = '0;
    logic [BLINK_W-1:0] blinks = '0;
    logic finished = 1'b0;

    t_res levels_due[$];
    int mismatches = 0;
    int items_sent = 0;
    int sequences_done = 0;
    int reg_writes = 0;
    int results_checked = 0;
    int cycle_count = 0;
    int hold_request = 0;
    int hold_left = 0;
    bit steady = 1'b0;

    alert_pattern_sequencer #(.TIME_WIDTH(TW)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit span_reached(logic [MS_W-1:0] len);
        longint lim;
        lim = longint'(len);
        if (lim > ELAPSED_MAX) lim = ELAPSED_MAX;
        return longint'(elapsed) >= lim;
    endfunction

    function automatic void enter_phase(logic [2:0] p);
        ph = p;
        elapsed = '0;
    endfunction

    function automatic void start_led();
        if (!alert_cfg.led_enable) begin
            enter_phase(PH_IDLE);
            finished = 1'b1;
        end else begin
            enter_phase(PH_LED_ON);
        end
    endfunction

    function automatic void start_vibe();
        if (!alert_cfg.vibration_enable) start_led();
        else enter_phase(PH_VIBRATE);
    endfunction

    function automatic void start_buzz();
        if (!alert_cfg.buzzer_enable) start_vibe();
        else enter_phase(PH_BUZZ_ON);
    endfunction

    function automatic void tick_phase();
        if (ph == PH_IDLE) return;
        if (longint'(elapsed) < ELAPSED_MAX) elapsed++;
        case (ph)
            PH_BUZZ_ON: begin
                if (span_reached(alert_cfg.buzzer_ms)) begin
                    if (beeps != 0) beeps--;
                    if (beeps != 0) enter_phase(PH_BUZZ_OFF);
                    else start_vibe();
                end
            end
            PH_BUZZ_OFF: begin
                if (span_reached(alert_cfg.buzzer_ms)) start_buzz();
            end
            PH_VIBRATE: begin
                if (span_reached(alert_cfg.vibration_ms)) start_led();
            end
            PH_LED_ON: begin
                if (span_reached(alert_cfg.blink_ms)) begin
                    if (blinks != 0) blinks--;
                    if (blinks != 0) begin
                        enter_phase(PH_LED_OFF);
                    end else begin
                        enter_phase(PH_IDLE);
                        finished = 1'b1;
                    end
                end
            end
            PH_LED_OFF: begin
                if (span_reached(alert_cfg.blink_ms)) start_led();
            end
            default: enter_phase(PH_IDLE);
        endcase
    endfunction

    function automatic t_res pattern_step(t_item w);
        t_res r;
        finished = 1'b0;
        case (w.operation)
            OP_TICK: tick_phase();
            OP_TRIGGER: begin
                if (ph == PH_IDLE) begin
                    beeps = w.alert_drowsy ? BEEPS_DROWSY : BEEPS_NORMAL;
                    blinks = alert_cfg.blink_count;
                    start_buzz();
                end
            end
            OP_ABORT: begin
                enter_phase(PH_IDLE);
                beeps = '0;
                blinks = '0;
            end
            default: ;
        endcase
        r.buzz_level = (ph == PH_BUZZ_ON);
        r.vibration_on = (ph == PH_VIBRATE);
        r.led_on = (ph == PH_LED_ON);
        r.busy_res = (ph != PH_IDLE);
        r.phase_now = ph;
        r.alert_done = finished;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH at result %0d: %s", results_checked, what);
    endtask

    task automatic send_word(input logic [1:0] op, input logic drowsy);
        t_item w;
        w.operation = op;
        w.alert_drowsy = drowsy;
        if (!steady) begin
            while ($urandom_range(99) < 11) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        levels_due.push_back(pattern_step(w));
        if (levels_due[$].alert_done) sequences_done++;
        items_sent++;
    endtask

    // Always passes at least one edge, so a following word never lowers and
    // raises valid in the same step.
    task automatic wait_all_levels();
        in_valid <= 1'b0;
        do @(posedge clk); while (levels_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_BUZZER_EN:    alert_cfg.buzzer_enable = value[0];
            REG_VIBRATION_EN: alert_cfg.vibration_enable = value[0];
            REG_LED_EN:       alert_cfg.led_enable = value[0];
            REG_BUZZER_MS:    alert_cfg.buzzer_ms = value[MS_W-1:0];
            REG_VIBRATION_MS: alert_cfg.vibration_ms = value[MS_W-1:0];
            REG_BLINK_MS:     alert_cfg.blink_ms = value[MS_W-1:0];
            REG_BLINK_COUNT:  alert_cfg.blink_count = value[BLINK_W-1:0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_setup(input t_cfg c);
        write_reg(REG_BUZZER_EN, CFG_DATA_W'(c.buzzer_enable));
        write_reg(REG_VIBRATION_EN, CFG_DATA_W'(c.vibration_enable));
        write_reg(REG_LED_EN, CFG_DATA_W'(c.led_enable));
        write_reg(REG_BUZZER_MS, CFG_DATA_W'(c.buzzer_ms));
        write_reg(REG_VIBRATION_MS, CFG_DATA_W'(c.vibration_ms));
        write_reg(REG_BLINK_MS, CFG_DATA_W'(c.blink_ms));
        write_reg(REG_BLINK_COUNT, CFG_DATA_W'(c.blink_count));
    endtask

    function automatic logic [MS_W-1:0] random_span(int short_max, int long_max);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return '1;
        if (roll < 18) return MS_W'($urandom_range(long_max, short_max + 1));
        return MS_W'($urandom_range(short_max, 0));
    endfunction

    function automatic t_cfg random_setup();
        t_cfg c;
        c.buzzer_enable = ($urandom_range(99) < 80);
        c.vibration_enable = ($urandom_range(99) < 80);
        c.led_enable = ($urandom_range(99) < 80);
        c.buzzer_ms = random_span(4, 30);
        c.vibration_ms = random_span(6, 40);
        c.blink_ms = random_span(3, 20);
        c.blink_count = ($urandom_range(19) == 0) ? 8'd255 : BLINK_W'($urandom_range(5, 0));
        return c;
    endfunction

    // Mostly well-formed alerts: trigger from idle, then ticks, with a few aborts,
    // ignored triggers and unused codes mixed in.
    task automatic send_random_word();
        int roll;
        logic [1:0] op;
        roll = $urandom_range(99);
        if (ph == PH_IDLE) begin
            if (roll < 80) op = OP_TRIGGER;
            else if (roll < 90) op = OP_TICK;
            else if (roll < 95) op = OP_ABORT;
            else op = OP_UNUSED;
        end else begin
            if (roll < 90) op = OP_TICK;
            else if (roll < 94) op = OP_TRIGGER;
            else if (roll < 97) op = OP_ABORT;
            else op = OP_UNUSED;
        end
        send_word(op, 1'($urandom_range(1)));
    endtask

    task automatic test_idle_commands();
        send_word(OP_TICK, 1'b0);
        send_word(OP_UNUSED, 1'b1);
        send_word(OP_ABORT, 1'b1);
        send_word(OP_TRIGGER, 1'b1);
        send_word(OP_TICK, 1'b0);
        send_word(OP_TICK, 1'b1);
        send_word(OP_TRIGGER, 1'b0);
        send_word(OP_UNUSED, 1'b0);
        send_word(OP_ABORT, 1'b0);
    endtask

    // With every output off, a trigger skips every phase and finishes in one word.
    task automatic test_all_outputs_disabled();
        wait_all_levels();
        write_reg(REG_BUZZER_EN, '0);
        write_reg(REG_VIBRATION_EN, '0);
        write_reg(REG_LED_EN, '0);
        send_word(OP_TRIGGER, 1'b0);
        send_word(OP_TRIGGER, 1'b1);
        send_word(OP_TICK, 1'b0);
    endtask

    task automatic test_zero_lengths();
        int guard;
        guard = 0;
        wait_all_levels();
        write_setup('{buzzer_enable: 1'b1, vibration_enable: 1'b1, led_enable: 1'b1,
                      buzzer_ms: '0, vibration_ms: '0, blink_ms: '0, blink_count: '0});
        send_word(OP_TRIGGER, 1'b0);
        while (ph != PH_IDLE && guard < 10) begin
            send_word(OP_TICK, 1'b0);
            guard++;
        end
    endtask

    task automatic test_longest_settings();
        wait_all_levels();
        write_setup('{buzzer_enable: 1'b1, vibration_enable: 1'b1, led_enable: 1'b1,
                      buzzer_ms: '1, vibration_ms: '1, blink_ms: '1, blink_count: '1});
        send_word(OP_TRIGGER, 1'b1);
        repeat (3) send_word(OP_TICK, 1'b1);
        send_word(OP_ABORT, 1'b1);
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_stall();
        wait_all_levels();
        write_setup('{buzzer_enable: 1'b1, vibration_enable: 1'b1, led_enable: 1'b1,
                      buzzer_ms: 16'd2, vibration_ms: 16'd3, blink_ms: 16'd1,
                      blink_count: 8'd2});
        hold_request = 50;
        repeat (40) send_random_word();
        wait_all_levels();
    endtask

    // Registers change only with the pipe drained, but the sequencer may be mid-alert,
    // so enable changes during a running phase are exercised too.
    task automatic test_random_alerts();
        int start_count;
        int round;
        int words;
        start_count = items_sent;
        round = 0;
        while (items_sent - start_count < RANDOM_WORDS) begin
            wait_all_levels();
            write_setup(random_setup());
            steady = (round == 4);
            words = $urandom_range(90, 30);
            repeat (words) begin
                send_random_word();
                if ($urandom_range(59) == 0) wait_all_levels();
            end
            round++;
        end
        steady = 1'b0;
    endtask

    always @(posedge clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= 11);
        end
    end

    always @(posedge clk) begin
        t_res want;
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (levels_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", out_data));
            end else begin
                want = levels_due.pop_front();
                if (out_data.buzz_level !== want.buzz_level)
                    report_mismatch($sformatf("buzz_level %b, want %b",
                                              out_data.buzz_level, want.buzz_level));
                if (out_data.vibration_on !== want.vibration_on)
                    report_mismatch($sformatf("vibration_on %b, want %b",
                                              out_data.vibration_on, want.vibration_on));
                if (out_data.led_on !== want.led_on)
                    report_mismatch($sformatf("led_on %b, want %b",
                                              out_data.led_on, want.led_on));
                if (out_data.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res %b, want %b",
                                              out_data.busy_res, want.busy_res));
                if (out_data.phase_now !== want.phase_now)
                    report_mismatch($sformatf("phase_now %0d, want %0d",
                                              out_data.phase_now, want.phase_now));
                if (out_data.alert_done !== want.alert_done)
                    report_mismatch($sformatf("alert_done %b, want %b",
                                              out_data.alert_done, want.alert_done));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, levels_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_commands();
        test_all_outputs_disabled();
        test_zero_lengths();
        test_longest_settings();
        test_output_stall();
        test_random_alerts();
        wait_all_levels();
        repeat (8) @(posedge clk);
        if (levels_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", levels_due.size()));
        $display("Sent %0d words over %0d register writes; %0d results checked,",
                 items_sent, reg_writes, results_checked);
        $display("%0d alerts ran to completion, %0d mismatches.", sequences_done, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
